// File: rtl/core/icmp_echo_reply_builder_defines.svh
// ----------------------------------------------------------------------------
// icmp echo reply builder assertion macros
// shared concurrent check helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ICMP_ECHO_REPLY_BUILDER_DEFINES_SVH
`define ICMP_ECHO_REPLY_BUILDER_DEFINES_SVH
`ifndef SYNTHESIS
`define ERB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("erb assertion failed");
`define ERB_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("erb forbidden condition");
`else
`define ERB_ASSERT(lbl, clk, rst_n, prop)
`define ERB_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/icmp_erb_pkg.sv
// ----------------------------------------------------------------------------
// icmp_erb_pkg
// word types and constants of the icmp echo reply builder
// ----------------------------------------------------------------------------
package icmp_erb_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] frame_byte;
        logic       frame_last;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  verdict;
        logic [11:0] reply_length;
        logic [7:0]  reply_byte;
        logic        reply_last;
    } out_t;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_BYTE    = 1'b1;

    localparam logic [2:0] V_OK       = 3'd0;
    localparam logic [2:0] V_SHORT    = 3'd1;
    localparam logic [2:0] V_NOT_IPV4 = 3'd2;
    localparam logic [2:0] V_NOT_ICMP = 3'd3;
    localparam logic [2:0] V_NOT_ECHO = 3'd4;
    localparam logic [2:0] V_BAD_LEN  = 3'd5;
    localparam logic [2:0] V_TOO_LONG = 3'd6;
    localparam logic [2:0] V_BUSY     = 3'd7;

    localparam int HDR_BYTES   = 42;
    localparam int ETH_BYTES   = 14;
    localparam int MIN_IP_LEN  = 28;
    localparam logic [7:0] VER_IHL   = 8'h45;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] ECHO_REQ  = 8'd8;
    localparam logic [7:0] IP_TTL    = 8'd64;

endpackage

// File: rtl/core/icmp_erb_csum.sv
// ----------------------------------------------------------------------------
// icmp_erb_csum
// folds a raw 16-bit word sum to a one's-complement checksum
// ----------------------------------------------------------------------------
module icmp_erb_csum (
    input  logic [32:0] sum,
    output logic [15:0] csum
);
    logic [17:0] s1;
    logic [16:0] s2;
    logic [16:0] s3;

    always_comb
    begin
        s1   = 18'(sum[15:0]) + 18'(sum[32:16]);
        s2   = 17'(s1[15:0]) + 17'(s1[17:16]);
        s3   = 17'(s2[15:0]) + 17'(s2[16]);
        csum = ~s3[15:0];
    end
endmodule

// File: rtl/core/icmp_echo_reply_builder.sv
// ----------------------------------------------------------------------------
// icmp_echo_reply_builder
// captures an ethernet frame, checks for an icmp echo request, and streams
// the echo reply one byte per tick
// ----------------------------------------------------------------------------
// A frame byte is taken every cycle while the block is idle; the byte marked
// last is followed by the checksum state and the check state, which loads its
// verdict word once the output is free. A tick does a registered read of the
// payload memory, then selects and loads the reply byte. The output register
// lets the block take a new word while a finished word waits. The payload
// memory needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "icmp_echo_reply_builder_defines.svh"

module icmp_echo_reply_builder #(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [47:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  icmp_erb_pkg::in_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output icmp_erb_pkg::out_t out_word
);
    import icmp_erb_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 2);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_VERD = 2'd2;
    localparam logic [1:0] ST_TICK = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [47:0]   own_mac_reg;
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic          blocked_reg, blocked_next;
    logic          reply_pending_reg, reply_pending_next;
    logic [CW-1:0] drain_index_reg, drain_index_next;
    logic [CW-1:0] reply_len_reg, reply_len_next;
    logic          out_valid_reg, out_valid_next;
    out_t          out_word_reg, out_word_next;

    logic [47:0] peer_mac_reg;
    logic [31:0] sender_ip_reg, target_ip_reg;
    logic [15:0] ip_ident_reg, ip_total_length_reg;
    logic [7:0]  version_ihl_reg, ip_protocol_reg, icmp_kind_reg;
    logic [15:0] echo_ident_reg, echo_sequence_reg;
    logic [31:0] payload_sum_reg;
    logic [32:0] ip_raw_reg, icmp_raw_reg;
    logic [15:0] ip_csum_reg, icmp_csum_reg;
    logic [15:0] ip_csum, icmp_csum;

    logic [7:0]    mem [BUFFER_BYTES];
    logic [7:0]    mem_rd_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;

    logic          in_acc, out_free, blocked_eff, cap_en, fin;
    logic [CW-1:0] pos;
    logic [2:0]    verdict;
    logic [7:0]    tick_byte;
    logic [CW-1:0] drain_inc;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign pos         = byte_count_reg;
    assign blocked_eff = (pos == '0) ? reply_pending_reg : blocked_reg;
    assign cap_en      = in_acc && (in_word.op == OP_BYTE) && !blocked_eff
                         && (pos < CW'(BUFFER_BYTES));
    assign mem_we      = cap_en && (pos >= CW'(HDR_BYTES));
    assign mem_wa      = AW'(pos - CW'(HDR_BYTES));
    assign mem_re      = in_acc && (in_word.op == OP_TICK) && reply_pending_reg;
    assign mem_ra      = AW'(drain_index_reg - CW'(HDR_BYTES));
    assign drain_inc   = drain_index_reg + CW'(1);
    assign fin         = (drain_inc >= reply_len_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= in_word.frame_byte;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[mem_ra];
        end
    end

    icmp_erb_csum u_ip_csum (
        .sum  (ip_raw_reg),
        .csum (ip_csum)
    );

    icmp_erb_csum u_icmp_csum (
        .sum  (icmp_raw_reg),
        .csum (icmp_csum)
    );

    // header capture and payload sum
    always_ff @(posedge clk)
    begin
        if (cap_en)
        begin
            if (pos == '0)
            begin
                payload_sum_reg <= '0;
            end
            if (pos >= CW'(6) && pos < CW'(12))
            begin
                peer_mac_reg <= {peer_mac_reg[39:0], in_word.frame_byte};
            end
            else if (pos == CW'(14))
            begin
                version_ihl_reg <= in_word.frame_byte;
            end
            else if (pos == CW'(16) || pos == CW'(17))
            begin
                ip_total_length_reg <= {ip_total_length_reg[7:0], in_word.frame_byte};
            end
            else if (pos == CW'(18) || pos == CW'(19))
            begin
                ip_ident_reg <= {ip_ident_reg[7:0], in_word.frame_byte};
            end
            else if (pos == CW'(23))
            begin
                ip_protocol_reg <= in_word.frame_byte;
            end
            else if (pos >= CW'(26) && pos < CW'(30))
            begin
                sender_ip_reg <= {sender_ip_reg[23:0], in_word.frame_byte};
            end
            else if (pos >= CW'(30) && pos < CW'(34))
            begin
                target_ip_reg <= {target_ip_reg[23:0], in_word.frame_byte};
            end
            else if (pos == CW'(34))
            begin
                icmp_kind_reg <= in_word.frame_byte;
            end
            else if (pos == CW'(38) || pos == CW'(39))
            begin
                echo_ident_reg <= {echo_ident_reg[7:0], in_word.frame_byte};
            end
            else if (pos == CW'(40) || pos == CW'(41))
            begin
                echo_sequence_reg <= {echo_sequence_reg[7:0], in_word.frame_byte};
            end
            else if (pos >= CW'(HDR_BYTES))
            begin
                if (ip_total_length_reg >= 16'(MIN_IP_LEN)
                    && 17'(pos) < 17'(ip_total_length_reg) + 17'(ETH_BYTES))
                begin
                    payload_sum_reg <= payload_sum_reg
                        + (pos[0] ? 32'(in_word.frame_byte)
                                  : 32'({in_word.frame_byte, 8'h00}));
                end
            end
        end
        if (state_reg == ST_SUM)
        begin
            ip_raw_reg <= 33'(16'h4500) + 33'(ip_total_length_reg) + 33'(ip_ident_reg)
                + 33'(16'h4000) + 33'(16'h4001)
                + 33'(target_ip_reg[31:16]) + 33'(target_ip_reg[15:0])
                + 33'(sender_ip_reg[31:16]) + 33'(sender_ip_reg[15:0]);
            icmp_raw_reg <= 33'(echo_ident_reg) + 33'(echo_sequence_reg)
                + 33'(payload_sum_reg);
        end
        if (state_reg == ST_VERD && out_free && verdict == V_OK)
        begin
            ip_csum_reg   <= ip_csum;
            icmp_csum_reg <= icmp_csum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
        end
        else if (cfg_we)
        begin
            own_mac_reg <= cfg_data;
        end
    end

    always_comb
    begin
        priority if (blocked_reg)                              verdict = V_BUSY;
        else if (byte_count_reg > CW'(BUFFER_BYTES))           verdict = V_TOO_LONG;
        else if (byte_count_reg < CW'(HDR_BYTES))              verdict = V_SHORT;
        else if (version_ihl_reg != VER_IHL)                   verdict = V_NOT_IPV4;
        else if (ip_protocol_reg != PROTO_ICMP)                verdict = V_NOT_ICMP;
        else if (icmp_kind_reg != ECHO_REQ)                    verdict = V_NOT_ECHO;
        else if (ip_total_length_reg < 16'(MIN_IP_LEN)
                 || 17'(ip_total_length_reg) + 17'(ETH_BYTES) > 17'(byte_count_reg))
                                                               verdict = V_BAD_LEN;
        else                                                   verdict = V_OK;
    end

    // reply byte selection
    always_comb
    begin
        tick_byte = mem_rd_reg;
        if (drain_index_reg < CW'(6))
        begin
            tick_byte = peer_mac_reg[8 * (3'd5 - drain_index_reg[2:0]) +: 8];
        end
        else if (drain_index_reg < CW'(12))
        begin
            tick_byte = own_mac_reg[8 * (3'd5 - 3'(drain_index_reg - CW'(6))) +: 8];
        end
        else if (drain_index_reg < CW'(26))
        begin
            unique case (drain_index_reg[4:0])
                5'd12:   tick_byte = 8'h08;
                5'd14:   tick_byte = VER_IHL;
                5'd16:   tick_byte = ip_total_length_reg[15:8];
                5'd17:   tick_byte = ip_total_length_reg[7:0];
                5'd18:   tick_byte = ip_ident_reg[15:8];
                5'd19:   tick_byte = ip_ident_reg[7:0];
                5'd20:   tick_byte = 8'h40;
                5'd22:   tick_byte = IP_TTL;
                5'd23:   tick_byte = PROTO_ICMP;
                5'd24:   tick_byte = ip_csum_reg[15:8];
                5'd25:   tick_byte = ip_csum_reg[7:0];
                default: tick_byte = 8'h00;
            endcase
        end
        else if (drain_index_reg < CW'(30))
        begin
            tick_byte = target_ip_reg[8 * (2'd3 - 2'(drain_index_reg - CW'(26))) +: 8];
        end
        else if (drain_index_reg < CW'(34))
        begin
            tick_byte = sender_ip_reg[8 * (2'd3 - 2'(drain_index_reg - CW'(30))) +: 8];
        end
        else if (drain_index_reg < CW'(HDR_BYTES))
        begin
            unique case (drain_index_reg[5:0])
                6'd36:   tick_byte = icmp_csum_reg[15:8];
                6'd37:   tick_byte = icmp_csum_reg[7:0];
                6'd38:   tick_byte = echo_ident_reg[15:8];
                6'd39:   tick_byte = echo_ident_reg[7:0];
                6'd40:   tick_byte = echo_sequence_reg[15:8];
                6'd41:   tick_byte = echo_sequence_reg[7:0];
                default: tick_byte = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        byte_count_next    = byte_count_reg;
        blocked_next       = blocked_reg;
        reply_pending_next = reply_pending_reg;
        drain_index_next   = drain_index_reg;
        reply_len_next     = reply_len_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_word_next      = out_word_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_word.op == OP_TICK)
                    begin
                        if (reply_pending_reg)
                        begin
                            state_next = ST_TICK;
                        end
                    end
                    else
                    begin
                        if (pos == '0)
                        begin
                            blocked_next = reply_pending_reg;
                        end
                        if (byte_count_reg <= CW'(BUFFER_BYTES))
                        begin
                            byte_count_next = byte_count_reg + CW'(1);
                        end
                        if (in_word.frame_last)
                        begin
                            state_next = ST_SUM;
                        end
                    end
                end
            end
            ST_SUM:
            begin
                state_next = ST_VERD;
            end
            ST_VERD:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_word_next              = '0;
                    out_word_next.kind         = KIND_VERDICT;
                    out_word_next.verdict      = verdict;
                    if (verdict == V_OK)
                    begin
                        reply_len_next     = CW'(ip_total_length_reg) + CW'(ETH_BYTES);
                        reply_pending_next = 1'b1;
                        drain_index_next   = '0;
                        out_word_next.reply_length =
                            12'(ip_total_length_reg) + 12'(ETH_BYTES);
                    end
                    byte_count_next = '0;
                    blocked_next    = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next            = '0;
                    out_word_next.kind       = KIND_BYTE;
                    out_word_next.reply_byte = tick_byte;
                    out_word_next.reply_last = fin;
                    drain_index_next         = fin ? '0 : drain_inc;
                    reply_pending_next       = !fin;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            byte_count_reg    <= '0;
            blocked_reg       <= 1'b0;
            reply_pending_reg <= 1'b0;
            drain_index_reg   <= '0;
            reply_len_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            byte_count_reg    <= byte_count_next;
            blocked_reg       <= blocked_next;
            reply_pending_reg <= reply_pending_next;
            drain_index_reg   <= drain_index_next;
            reply_len_reg     <= reply_len_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    `ERB_ASSERT(a_drain_in_range, clk, rst_n, reply_pending_reg |-> drain_index_reg < reply_len_reg)
    `ERB_ASSERT(a_reply_len_min, clk, rst_n, reply_pending_reg |-> reply_len_reg >= CW'(HDR_BYTES))
    `ERB_NEVER(a_count_sat, clk, rst_n, byte_count_reg > CW'(BUFFER_BYTES + 1))
    `ERB_ASSERT(a_drain_idle, clk, rst_n, !reply_pending_reg |-> drain_index_reg == '0)

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// icmp echo reply builder testbench
// drives frames and reply ticks with random gaps, predicts every verdict and
// reply byte, and checks the output words in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import icmp_erb_pkg::*;

    localparam int BUF_BYTES  = 2048;
    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [47:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    in_t         in_word;
    logic        out_valid;
    logic        out_stall;
    out_t        out_word;

    icmp_echo_reply_builder #(.BUFFER_BYTES(BUF_BYTES)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    // predictor state
    logic [47:0] m_own_mac;
    logic [7:0]  m_payload [BUF_BYTES];
    int unsigned m_count;
    logic [47:0] m_peer_mac;
    logic [31:0] m_sender_ip, m_target_ip;
    logic [15:0] m_ident, m_total_len, m_echo_id, m_echo_seq;
    logic [7:0]  m_ver_ihl, m_proto, m_icmp_type;
    logic [31:0] m_payload_sum;
    logic        m_pending, m_blocked;
    int unsigned m_drain, m_reply_len;

    out_t        expected_words[$];
    int          errors, words_seen, verdicts_seen, bytes_seen, idle_cycles;
    int          items_sent;
    logic        done;
    byte         frame[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [15:0] fold_not(logic [31:0] s);
        while (s[31:16] != 0)
            s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        return ~s[15:0];
    endfunction

    function automatic logic [7:0] reply_byte_at(int unsigned i);
        logic [15:0] c;
        if (i < 6) return m_peer_mac[8*(5-i) +: 8];
        if (i < 12) return m_own_mac[8*(11-i) +: 8];
        if (i >= 26 && i < 30) return m_target_ip[8*(29-i) +: 8];
        if (i >= 30 && i < 34) return m_sender_ip[8*(33-i) +: 8];
        case (i)
            12: return 8'h08;
            13: return 8'h00;
            14: return VER_IHL;
            15: return 8'h00;
            16: return m_total_len[15:8];
            17: return m_total_len[7:0];
            18: return m_ident[15:8];
            19: return m_ident[7:0];
            20: return 8'h40;
            21: return 8'h00;
            22: return IP_TTL;
            23: return PROTO_ICMP;
            24, 25:
            begin
                c = fold_not(32'h4500 + m_total_len + m_ident + 32'h4000 + 32'h4001
                    + m_target_ip[31:16] + m_target_ip[15:0]
                    + m_sender_ip[31:16] + m_sender_ip[15:0]);
                return (i == 24) ? c[15:8] : c[7:0];
            end
            34, 35: return 8'h00;
            36, 37:
            begin
                c = fold_not(m_echo_id + m_echo_seq + m_payload_sum);
                return (i == 36) ? c[15:8] : c[7:0];
            end
            38: return m_echo_id[15:8];
            39: return m_echo_id[7:0];
            40: return m_echo_seq[15:8];
            41: return m_echo_seq[7:0];
            default: ;
        endcase
        if (i - 42 < BUF_BYTES) return m_payload[i - 42];
        return 8'h00;
    endfunction

    function automatic void capture_byte(int unsigned pos, logic [7:0] b);
        int unsigned k;
        if (pos == 0) m_payload_sum = 0;
        if (pos >= 6 && pos < 12) m_peer_mac = {m_peer_mac[39:0], b};
        else if (pos == 14) m_ver_ihl = b;
        else if (pos == 16 || pos == 17) m_total_len = {m_total_len[7:0], b};
        else if (pos == 18 || pos == 19) m_ident = {m_ident[7:0], b};
        else if (pos == 23) m_proto = b;
        else if (pos >= 26 && pos < 30) m_sender_ip = {m_sender_ip[23:0], b};
        else if (pos >= 30 && pos < 34) m_target_ip = {m_target_ip[23:0], b};
        else if (pos == 34) m_icmp_type = b;
        else if (pos == 38 || pos == 39) m_echo_id = {m_echo_id[7:0], b};
        else if (pos == 40 || pos == 41) m_echo_seq = {m_echo_seq[7:0], b};
        else if (pos >= 42)
        begin
            k = pos - 42;
            if (k < BUF_BYTES) m_payload[k] = b;
            if (m_total_len >= 28 && k < m_total_len - 28)
                m_payload_sum += k[0] ? {24'h0, b} : {16'h0, b, 8'h0};
        end
    endfunction

    // works out the result of one accepted word
    function automatic void predict_word(in_t w);
        out_t r;
        logic [2:0] v;
        r = '0;
        if (w.op == OP_TICK)
        begin
            if (!m_pending) return;
            r.kind = KIND_BYTE;
            r.reply_byte = reply_byte_at(m_drain);
            m_drain++;
            if (m_drain >= m_reply_len)
            begin
                r.reply_last = 1'b1;
                m_pending = 1'b0;
                m_drain = 0;
            end
            expected_words.push_back(r);
            return;
        end
        if (m_count == 0) m_blocked = m_pending;
        if (!m_blocked && m_count < BUF_BYTES) capture_byte(m_count, w.frame_byte);
        if (m_count <= BUF_BYTES) m_count++;
        if (!w.frame_last) return;
        if (m_blocked) v = V_BUSY;
        else if (m_count > BUF_BYTES) v = V_TOO_LONG;
        else if (m_count < HDR_BYTES) v = V_SHORT;
        else if (m_ver_ihl != VER_IHL) v = V_NOT_IPV4;
        else if (m_proto != PROTO_ICMP) v = V_NOT_ICMP;
        else if (m_icmp_type != ECHO_REQ) v = V_NOT_ECHO;
        else if (m_total_len < MIN_IP_LEN || m_total_len + 14 > m_count) v = V_BAD_LEN;
        else v = V_OK;
        r.kind = KIND_VERDICT;
        r.verdict = v;
        if (v == V_OK)
        begin
            m_reply_len = m_total_len + ETH_BYTES;
            m_pending = 1'b1;
            m_drain = 0;
            r.reply_length = m_reply_len[11:0];
        end
        m_count = 0;
        m_blocked = 1'b0;
        expected_words.push_back(r);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0h want %0h (word %0d)", what, got, want, words_seen);
    endtask

    // result checker and output stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", int'(out_word), 0);
            else
            begin
                out_t e;
                e = expected_words.pop_front();
                if (out_word.kind != e.kind) report_mismatch("kind", out_word.kind, e.kind);
                if (out_word.verdict != e.verdict)
                    report_mismatch("verdict", out_word.verdict, e.verdict);
                if (out_word.reply_length != e.reply_length)
                    report_mismatch("reply_length", out_word.reply_length, e.reply_length);
                if (out_word.reply_byte != e.reply_byte)
                    report_mismatch("reply_byte", out_word.reply_byte, e.reply_byte);
                if (out_word.reply_last != e.reply_last)
                    report_mismatch("reply_last", out_word.reply_last, e.reply_last);
                if (e.kind == KIND_VERDICT) verdicts_seen++;
                else bytes_seen++;
            end
            words_seen++;
        end
    end

    initial
    begin : stall_gen
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (done || $urandom_range(0, 3) != 0) out_stall <= 1'b0;
            else
            begin
                n = gap_len();
                out_stall <= (n != 0);
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d words pending", expected_words.size());
            $display("FAIL icmp_echo_reply_builder");
            $finish;
        end
    end

    task automatic send_word(logic op, logic [7:0] b, logic last);
        in_t w;
        int n;
        n = gap_len();
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        w.op = op;
        w.frame_byte = b;
        w.frame_last = last;
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_word(w);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i]) send_word(OP_BYTE, frame[i], i == frame.size() - 1);
    endtask

    task automatic drain_reply(int extra);
        int n;
        n = m_pending ? m_reply_len - m_drain + extra : extra;
        repeat (n) send_word(OP_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_mac(logic [47:0] mac);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= mac;
        @(posedge clk);
        cfg_we <= 1'b0;
        m_own_mac = mac;
    endtask

    // builds an echo request with random content
    task automatic build_request(int pay, int pad, int ip_len_adj);
        int ip_len;
        ip_len = 28 + pay + ip_len_adj;
        frame.delete();
        repeat (6) frame.push_back(8'($urandom));
        repeat (6) frame.push_back(8'($urandom));
        frame.push_back(8'h08);
        frame.push_back(8'h00);
        frame.push_back(VER_IHL);
        frame.push_back(8'($urandom));
        frame.push_back(ip_len[15:8]);
        frame.push_back(ip_len[7:0]);
        repeat (5) frame.push_back(8'($urandom));
        frame.push_back(PROTO_ICMP);
        repeat (10) frame.push_back(8'($urandom));
        frame.push_back(ECHO_REQ);
        repeat (7) frame.push_back(8'($urandom));
        repeat (pay + pad) frame.push_back(8'($urandom));
    endtask

    task automatic test_directed();
        write_mac(48'hffff_ffff_ffff);
        build_request(0, 0, 0);
        send_frame();
        drain_reply(1);
        build_request(1, 3, 0);
        foreach (frame[i]) frame[i] = (i >= 42) ? 8'hff : frame[i];
        send_frame();
        // frame while a reply is pending, then drain
        build_request(4, 0, 0);
        send_frame();
        drain_reply(0);
        build_request(3, 0, 0);
        frame[14] = 8'h46;
        send_frame();
        build_request(3, 0, 0);
        frame[23] = 8'h06;
        send_frame();
        build_request(3, 0, 0);
        frame[34] = 8'h00;
        send_frame();
        build_request(3, 0, 1);
        send_frame();
        build_request(0, 0, -1);
        send_frame();
        build_request(0, 0, 0);
        void'(frame.pop_back());
        send_frame();
        send_word(OP_BYTE, 8'h00, 1'b1);
        write_mac(48'h0);
        build_request(7, 0, 0);
        send_frame();
        drain_reply(2);
    endtask

    task automatic test_random(int target);
        int kind;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 3) == 0) write_mac(48'({$urandom, $urandom}));
            kind = $urandom_range(0, 9);
            build_request($urandom_range(0, 24), $urandom_range(0, 2) == 0 ?
                $urandom_range(1, 6) : 0, 0);
            if (kind == 0) frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
            else if (kind == 1) repeat ($urandom_range(1, 20)) void'(frame.pop_back());
            else if (kind == 2) frame[17] = 8'($urandom);
            send_frame();
            if ($urandom_range(0, 4) == 0)
            begin
                build_request($urandom_range(0, 5), 0, 0);
                send_frame();
            end
            drain_reply($urandom_range(0, 2));
        end
    endtask

    initial
    begin
        errors = 0;
        words_seen = 0;
        verdicts_seen = 0;
        bytes_seen = 0;
        idle_cycles = 0;
        items_sent = 0;
        done = 1'b0;
        m_own_mac = '0;
        m_count = 0;
        m_peer_mac = '0;
        m_sender_ip = '0;
        m_target_ip = '0;
        m_ident = '0;
        m_total_len = '0;
        m_echo_id = '0;
        m_echo_seq = '0;
        m_ver_ihl = '0;
        m_proto = '0;
        m_icmp_type = '0;
        m_payload_sum = '0;
        m_pending = 1'b0;
        m_blocked = 1'b0;
        m_drain = 0;
        m_reply_len = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_word = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        in_valid <= 1'b0;
        done = 1'b1;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d input words, checked %0d verdicts and %0d reply bytes",
            items_sent, verdicts_seen, bytes_seen);
        if (errors == 0)
            $display("PASS icmp_echo_reply_builder");
        else
            $display("FAIL icmp_echo_reply_builder");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/icmp_erb_pkg.sv
rtl/core/icmp_erb_csum.sv
rtl/core/icmp_echo_reply_builder.sv
tb/tb.sv
